// ----- sv/byte_stuffed_frame_receiver_defines.svh -----
// Assertion macros for the frame receiver top module.
// No dependencies; expects clk and rst in the including scope.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define BSFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/bsfr_pkg.sv -----
// Shared constants and types for the byte-stuffed frame receiver.
// No dependencies.
package bsfr_pkg;

  localparam int MAX_FRAME = 64;
  localparam int ADDR_W    = $clog2(MAX_FRAME);
  localparam int LEN_W     = $clog2(MAX_FRAME + 1);
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd2;

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
  localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd126;
  localparam logic [BYTE_W-1:0] MASK_RESET   = 8'd32;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } rx_state_t;

endpackage

// ----- sv/byte_stuffed_frame_receiver.sv -----
// Frame receiver top: unstuffing control, registers and frame read-out.
// After the closing flag, the first frame byte passes read issue, buffer data and the output register.
// Throughput: one raw byte per cycle while collecting; read-out gives one byte
// per cycle through the buffer read port while the sink is ready, and input is
// held off until every read of the frame has been issued.
// Reset: synchronous, clears control state and counters, loads config defaults.
module byte_stuffed_frame_receiver import bsfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 frame_valid,
  input  logic                 frame_ready,
  output logic [BYTE_W-1:0]    frame_byte,
  output logic                 frame_last,
  output logic [CNT_W-1:0]     overflow_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

`include "byte_stuffed_frame_receiver_defines.svh"

  rx_state_t         state, state_next;
  logic [BYTE_W-1:0] escape_char, flag_char, mask_char;
  logic              escape_pending;
  logic [LEN_W-1:0]  frame_length;
  logic [CNT_W-1:0]  overflow_count;
  logic [ADDR_W-1:0] rd_idx;
  logic              rd_pend, rd_last;
  logic [CNT_W-1:0]  rd_ovf;
  logic [BYTE_W-1:0] mem_q;

  logic              rx_xfer, is_esc, is_flag, is_data, full;
  logic              mem_we, rd_en, rd_is_last, out_free, start_drain;
  logic [BYTE_W-1:0] data_val;

  assign cfg_ready  = 1'b1;
  assign rx_xfer    = rx_valid && rx_ready;
  assign is_esc     = rx_byte == escape_char;
  assign is_flag    = !is_esc && (rx_byte == flag_char);
  assign is_data    = !is_esc && !is_flag;
  assign full       = frame_length == LEN_W'(MAX_FRAME);
  assign data_val   = escape_pending ? (rx_byte ^ mask_char) : rx_byte;
  assign mem_we     = rx_xfer && is_data && !full;
  assign out_free   = !frame_valid || frame_ready;
  assign rd_is_last = ({1'b0, rd_idx} + LEN_W'(1)) == frame_length;
  assign start_drain = rx_xfer && is_flag && (frame_length != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start_drain) state_next = ST_DRAIN;
      ST_DRAIN: if (rd_en && rd_is_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rx_ready = 1'b0;
    rd_en    = 1'b0;
    unique case (state)
      ST_IDLE:  rx_ready = 1'b1;
      ST_DRAIN: rd_en = !rd_pend || out_free;
      default:  rx_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_char <= ESCAPE_RESET;
      flag_char   <= FLAG_RESET;
      mask_char   <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ESCAPE: escape_char <= cfg_data;
        REG_FLAG:   flag_char   <= cfg_data;
        REG_MASK:   mask_char   <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      frame_length   <= '0;
      overflow_count <= '0;
    end else begin
      if (rx_xfer) begin
        if (is_esc) begin
          escape_pending <= 1'b1;
        end else if (is_data) begin
          escape_pending <= 1'b0;
          if (full) begin
            frame_length <= '0;
            if (overflow_count != '1) overflow_count <= overflow_count + CNT_W'(1);
          end else begin
            frame_length <= frame_length + LEN_W'(1);
          end
        end
      end
      if (rd_en && rd_is_last) begin
        frame_length <= '0;
      end
    end
  end

  // read-out pipeline: read issue -> buffer data -> output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx      <= '0;
      rd_pend     <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (start_drain) begin
        rd_idx <= '0;
      end else if (rd_en) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
      if (rd_en) begin
        rd_pend <= 1'b1;
      end else if (out_free) begin
        rd_pend <= 1'b0;
      end
      if (rd_pend && out_free) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
    end
  end

  // count is captured at read issue; input may reopen before the last beat leaves
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_last <= rd_is_last;
      rd_ovf  <= overflow_count;
    end
    if (rd_pend && out_free) begin
      frame_byte     <= mem_q;
      frame_last     <= rd_last;
      overflow_total <= rd_ovf;
    end
  end

  bsfr_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (frame_length[ADDR_W-1:0]),
    .wdata (data_val),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (mem_q)
  );

  `BSFR_ASSERT_NOW(a_no_rw_overlap, mem_we, !rd_en, "buffer write during read-out")
  `BSFR_ASSERT_NOW(a_drain_nonempty, state == ST_DRAIN, frame_length != '0, "read-out of empty frame")
  `BSFR_ASSERT_NEXT(a_ovf_monotonic, 1'b1, overflow_count >= $past(overflow_count), "overflow count fell")
  `BSFR_ASSERT_NOW(a_len_bound, 1'b1, frame_length <= LEN_W'(MAX_FRAME), "frame length beyond capacity")

endmodule

// ----- sv/bsfr_store.sv -----
// Frame buffer: one write port, one read port with registered read data.
// Depends on bsfr_pkg.
module bsfr_store import bsfr_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [MAX_FRAME];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sim/frame_beat_checker.sv -----
`timescale 1ns / 100ps
// Checker for the byte-stuffed frame receiver: watches the rx, frame and cfg
// channels, keeps its own unstuffing state and compares every frame beat.
// Depends on bsfr_pkg for widths and register indexes.
module frame_beat_checker import bsfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  input  logic                 rx_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 frame_valid,
  input  logic                 frame_ready,
  input  logic [BYTE_W-1:0]    frame_byte,
  input  logic                 frame_last,
  input  logic [CNT_W-1:0]     overflow_total,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output logic [31:0]          fault_total,
  output logic [31:0]          beats_owed
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CNT_W-1:0]  drops;
  } frame_beat_t;

  frame_beat_t       owed_q[$];
  logic [BYTE_W-1:0] esc_reg;
  logic [BYTE_W-1:0] flag_reg;
  logic [BYTE_W-1:0] mask_reg;
  logic [BYTE_W-1:0] held [MAX_FRAME];
  logic [LEN_W-1:0]  held_len;
  logic              armed;
  logic [CNT_W-1:0]  drop_count;
  int                faults = 0;

  function void keep_byte(input logic [BYTE_W-1:0] b);
    if (held_len < MAX_FRAME) begin
      held[held_len[ADDR_W-1:0]] = b;
      held_len = held_len + 1'b1;
    end else begin
      // full buffer: drop the frame
      if (drop_count != '1) drop_count = drop_count + 1'b1;
      held_len = '0;
    end
  endfunction

  function void unstuff(input logic [BYTE_W-1:0] c);
    frame_beat_t beat;
    if (c == esc_reg) begin
      armed = 1'b1;
    end else if (c == flag_reg) begin
      // pending escape survives the flag
      for (int i = 0; i < held_len; i++) begin
        beat.data  = held[i];
        beat.last  = (i + 1 == held_len);
        beat.drops = drop_count;
        owed_q = {owed_q, beat};
      end
      held_len = '0;
    end else if (armed) begin
      armed = 1'b0;
      keep_byte(c ^ mask_reg);
    end else begin
      keep_byte(c);
    end
  endfunction

  always @(posedge clk) begin : watch
    frame_beat_t want;
    if (rst) begin
      esc_reg    = ESCAPE_RESET;
      flag_reg   = FLAG_RESET;
      mask_reg   = MASK_RESET;
      held_len   = '0;
      armed      = 1'b0;
      drop_count = '0;
      owed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ESCAPE: esc_reg = cfg_data;
          REG_FLAG:   flag_reg = cfg_data;
          REG_MASK:   mask_reg = cfg_data;
          default: ;
        endcase
      end
      if (rx_valid && rx_ready) unstuff(rx_byte);
      if (frame_valid && frame_ready) begin
        if (owed_q.size() == 0) begin
          faults++;
          $display("%0t: unexpected transfer, expected none, got byte %h last %b overflow %0d",
                   $time, frame_byte, frame_last, overflow_total);
        end else begin
          want = owed_q.pop_front();
          if (frame_byte !== want.data) begin
            faults++;
            $display("%0t: frame_byte expected %h got %h", $time, want.data, frame_byte);
          end
          if (frame_last !== want.last) begin
            faults++;
            $display("%0t: frame_last expected %b got %b", $time, want.last, frame_last);
          end
          if (overflow_total !== want.drops) begin
            faults++;
            $display("%0t: overflow_total expected %0d got %0d",
                     $time, want.drops, overflow_total);
          end
        end
      end
    end
    fault_total <= faults;
    beats_owed  <= owed_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Testbench top for byte_stuffed_frame_receiver: clock, reset, rx/cfg stimulus,
// frame sink with random stalls, and the verdict.
// Depends on bsfr_pkg, the receiver RTL and frame_beat_checker.
module testbench;
  import bsfr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 29;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 rx_valid = 1'b0;
  logic                 rx_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 frame_valid;
  logic                 frame_ready = 1'b0;
  logic [BYTE_W-1:0]    frame_byte;
  logic                 frame_last;
  logic [CNT_W-1:0]     overflow_total;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic [31:0]          fault_total;
  logic [31:0]          beats_owed;

  logic                 calm = 1'b0;
  logic                 hold_req = 1'b0;
  logic                 hold_seen = 1'b0;
  int                   hold_left = 0;
  logic [BYTE_W-1:0]    esc_c = ESCAPE_RESET;
  logic [BYTE_W-1:0]    flag_c = FLAG_RESET;
  logic [BYTE_W-1:0]    mask_c = MASK_RESET;
  int                   bytes_sent = 0;

  byte_stuffed_frame_receiver u_top (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_ready       (rx_ready),
    .rx_byte        (rx_byte),
    .frame_valid    (frame_valid),
    .frame_ready    (frame_ready),
    .frame_byte     (frame_byte),
    .frame_last     (frame_last),
    .overflow_total (overflow_total),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  frame_beat_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_ready       (rx_ready),
    .rx_byte        (rx_byte),
    .frame_valid    (frame_valid),
    .frame_ready    (frame_ready),
    .frame_byte     (frame_byte),
    .frame_last     (frame_last),
    .overflow_total (overflow_total),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fault_total    (fault_total),
    .beats_owed     (beats_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // frame sink: random stalls, plus one long hold-off per toggle of hold_req
  always @(posedge clk) begin
    if (rst) begin
      frame_ready <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      frame_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      frame_ready <= 1'b0;
    end else begin
      frame_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    bytes_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    while (b == esc_c || b == flag_c) b = BYTE_W'($urandom);
    return b;
  endfunction

  task automatic send_frame(input int len, input bit noisy, input bit closed);
    int                roll;
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      roll = noisy ? $urandom_range(99) : 99;
      if (roll < 12) begin
        send_byte(esc_c);
        if ($urandom_range(1)) b = ($urandom_range(1) ? esc_c : flag_c) ^ mask_c;
        else b = BYTE_W'($urandom);
        send_byte(b);
      end else if (roll < 16) begin
        send_byte(BYTE_W'($urandom));
      end else begin
        send_byte(plain_byte());
      end
    end
    if (closed) send_byte(flag_c);
  endtask

  task automatic random_frame();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 80) len = $urandom_range(10, 0);
    else if (pick < 93) len = $urandom_range(MAX_FRAME, 11);
    else len = $urandom_range(MAX_FRAME + 6, MAX_FRAME - 1);
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_frame(len, 1'b1, 1'b0);
    end else if (pick < 12) begin
      send_frame(len, 1'b1, 1'b0);
      send_byte(esc_c);
      send_byte(flag_c);
    end else begin
      send_frame(len, 1'b1, 1'b1);
    end
  endtask

  task automatic random_run(input int n);
    int stop;
    stop = bytes_sent + n;
    while (bytes_sent < stop) random_frame();
  endtask

  // wait until every owed beat is out, then let the read-out pipe empty
  task automatic settle();
    rx_valid <= 1'b0;
    do @(posedge clk); while (beats_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [BYTE_W-1:0] e, input logic [BYTE_W-1:0] f,
                          input logic [BYTE_W-1:0] m);
    cfg_put(REG_ESCAPE, e);
    cfg_put(REG_FLAG, f);
    cfg_put(REG_MASK, m);
    cfg_valid <= 1'b0;
    esc_c  = e;
    flag_c = f;
    mask_c = m;
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] opening [21] = '{
      8'h00, 8'hFF,
      ESCAPE_RESET, FLAG_RESET ^ MASK_RESET,
      ESCAPE_RESET, ESCAPE_RESET ^ MASK_RESET,
      FLAG_RESET,
      FLAG_RESET,
      ESCAPE_RESET, ESCAPE_RESET, 8'h01,
      ESCAPE_RESET, FLAG_RESET,
      8'h41, FLAG_RESET,
      8'hAA, ESCAPE_RESET, FLAG_RESET, FLAG_RESET,
      8'h55, FLAG_RESET
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_byte(opening[i]);
    random_run(15);

    // long sink hold-off: a full frame, an overflowing one, then a short one
    hold_req <= ~hold_req;
    send_frame(MAX_FRAME, 1'b0, 1'b1);
    send_frame(MAX_FRAME + 2, 1'b0, 1'b1);
    send_frame(5, 1'b1, 1'b1);
    settle();

    cfg_put(REG_UNUSED, 8'h5A);
    set_regs(8'h00, 8'hFF, 8'hFF);
    calm <= 1'b1;
    random_run(12);
    settle();
    calm <= 1'b0;

    set_regs(8'hFF, 8'h00, 8'h00);
    random_run(12);
    settle();

    // escape and flag equal: escape wins, frames only end by overflow
    set_regs(8'h55, 8'h55, 8'hAA);
    random_run(8);
    settle();

    set_regs(8'h3C, 8'hC3, 8'h3C);
    random_run(10);
    settle();

    set_regs(8'h11, 8'h22, 8'h22);
    random_run(10);

    repeat (2) begin
      settle();
      set_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      random_run(12);
    end

    settle();
    set_regs(ESCAPE_RESET, FLAG_RESET, MASK_RESET);
    random_run(12);
    settle();

    if (fault_total == 0 && beats_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bsfr_pkg.sv
sv/bsfr_store.sv
sv/byte_stuffed_frame_receiver.sv
sim/frame_beat_checker.sv
sim/testbench.sv
